>>> sv/hfpd_pkg.sv
// Shared types and constants of the display-panel frame parameter decoder.
`default_nettype none
package hfpd_pkg;

  // Frame layout
  localparam int unsigned FRAME_LENGTH_DEF = 9;
  localparam logic [7:0]  HDR_FIRST        = 8'h5A;
  localparam logic [7:0]  HDR_SECOND       = 8'hA5;
  localparam int unsigned ID_HI_POS        = 4;
  localparam int unsigned ID_LO_POS        = 5;
  localparam int unsigned VALUE_POS        = 8;

  // Parameter ids
  localparam logic [15:0] ID_SPEED       = 16'h1000;
  localparam logic [15:0] ID_ANGLE       = 16'h1001;
  localparam logic [15:0] ID_REPEAT      = 16'h1002;
  localparam logic [15:0] ID_PAUSE       = 16'h1003;
  localparam logic [15:0] ID_TORQUE      = 16'h1100;
  localparam logic [15:0] ID_BUTTON      = 16'h3000;
  localparam logic [15:0] ID_BUTTON_MODE = 16'h3100;
  localparam logic [15:0] ID_MODE        = 16'h4000;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Run state codes
  localparam logic [2:0] RUN_IDLE    = 3'd0;
  localparam logic [2:0] RUN_RUNNING = 3'd1;
  localparam logic [2:0] RUN_PAUSED  = 3'd2;
  localparam logic [2:0] RUN_STOPPED = 3'd3;
  localparam logic [2:0] RUN_ESTOP   = 3'd4;

  // Operating mode codes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_ACTIVE  = 2'd1;
  localparam logic [1:0] MODE_PASSIVE = 2'd2;
  localparam logic [1:0] MODE_FORCE   = 2'd3;

  // Passive submode codes
  localparam logic [1:0] SUB_ASSIST = 2'd0;

  // Button values
  localparam logic [7:0] BTN_START    = 8'd1;
  localparam logic [7:0] BTN_PAUSE    = 8'd2;
  localparam logic [7:0] BTN_STOP     = 8'd3;
  localparam logic [7:0] BTN_IDLE     = 8'd4;
  localparam logic [7:0] BTN_ESTOP    = 8'd5;
  localparam logic [7:0] BTN_SUB_LO   = 8'd6;
  localparam logic [7:0] BTN_SUB_HI   = 8'd8;

  // Mode select values
  localparam logic [7:0] SEL_ACTIVE  = 8'd1;
  localparam logic [7:0] SEL_PASSIVE = 8'd2;
  localparam logic [7:0] SEL_FORCE   = 8'd3;

  // Reset values of the settings
  localparam logic [7:0] SPEED_RST   = 8'd1;
  localparam logic [7:0] ANGLE_RST   = 8'd1;
  localparam logic [7:0] REPEAT_RST  = 8'd10;
  localparam logic [7:0] PAUSE_RST   = 8'd1;
  localparam logic [7:0] TORQUE_RST  = 8'd10;
  localparam logic [7:0] TORQUE_BASE = 8'd8;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SPEED,
    OP_ANGLE,
    OP_REPEAT,
    OP_PAUSE,
    OP_TORQUE,
    OP_BUTTON,
    OP_BUTTON_MODE,
    OP_MODE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] speed_setting;
    logic [7:0] angle_limit;
    logic [7:0] repeat_setting;
    logic [7:0] pause_seconds;
    logic [7:0] torque_setting;
    logic [2:0] run_state;
    logic [1:0] operating_mode;
    logic [1:0] passive_submode;
    logic       start_pulse;
    logic       reinit_pulse;
  } result_t;

  // Map a parameter id to its command
  function automatic op_t classify_id(input logic [15:0] id);
    op_t op;
    case (id)
      ID_SPEED:       op = OP_SPEED;
      ID_ANGLE:       op = OP_ANGLE;
      ID_REPEAT:      op = OP_REPEAT;
      ID_PAUSE:       op = OP_PAUSE;
      ID_TORQUE:      op = OP_TORQUE;
      ID_BUTTON:      op = OP_BUTTON;
      ID_BUTTON_MODE: op = OP_BUTTON_MODE;
      ID_MODE:        op = OP_MODE;
      default:        op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

>>> sv/hfpd_front.sv
// Frame hunter: header match, byte position, id/value capture and command issue.
`default_nettype none
module hfpd_front #(
  parameter int unsigned FRAME_LENGTH = hfpd_pkg::FRAME_LENGTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          byte_take,
  input  wire logic [7:0]    rx_byte,
  output hfpd_pkg::cmd_t     cmd,
  output logic               cmd_push
);
  import hfpd_pkg::*;

  localparam int unsigned PosW = $clog2(FRAME_LENGTH + 1);
  localparam logic [PosW-1:0] PosHdr2  = PosW'(1);
  localparam logic [PosW-1:0] PosBody  = PosW'(2);
  localparam logic [PosW-1:0] PosIdHi  = PosW'(ID_HI_POS);
  localparam logic [PosW-1:0] PosIdLo  = PosW'(ID_LO_POS);
  localparam logic [PosW-1:0] PosValue = PosW'(VALUE_POS);
  localparam logic [PosW-1:0] PosLast  = PosW'(FRAME_LENGTH - 1);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [7:0]      id_hi_r, id_hi_nxt;
  logic [7:0]      id_lo_r, id_lo_nxt;
  logic [7:0]      val_r, val_nxt;

  // Position tracking and field capture
  always_comb begin
    pos_nxt   = pos_r;
    id_hi_nxt = id_hi_r;
    id_lo_nxt = id_lo_r;
    val_nxt   = val_r;
    cmd_push  = 1'b0;
    cmd.op    = classify_id({id_hi_r, id_lo_r});
    cmd.value = (pos_r == PosValue) ? rx_byte : val_r;
    if (byte_take) begin
      if (pos_r == '0) begin
        if (rx_byte == HDR_FIRST) pos_nxt = PosHdr2;
      end else if (pos_r == PosHdr2) begin
        // a bad second byte goes back to the hunt, never restarts a frame
        pos_nxt = (rx_byte == HDR_SECOND) ? PosBody : '0;
      end else begin
        if (pos_r == PosIdHi)  id_hi_nxt = rx_byte;
        if (pos_r == PosIdLo)  id_lo_nxt = rx_byte;
        if (pos_r == PosValue) val_nxt   = rx_byte;
        if (pos_r == PosLast) begin
          cmd_push = 1'b1;
          pos_nxt  = '0;
        end else begin
          pos_nxt = pos_r + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Captured bytes need no reset
  always_ff @(posedge clk) begin
    id_hi_r <= id_hi_nxt;
    id_lo_r <= id_lo_nxt;
    val_r   <= val_nxt;
  end

endmodule
`default_nettype wire

>>> sv/hfpd_queue.sv
// Short command queue between the frame hunter and the settings unit.
`default_nettype none
module hfpd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hfpd_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output hfpd_pkg::cmd_t      pop_data,
  output logic                empty
);
  import hfpd_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            slots_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full     = (count_r == CntW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slots_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) count_nxt = count_r + CntW'(1);
    else if (pop && !push) count_nxt = count_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

>>> sv/hfpd_back.sv
// Settings unit: applies one command per cycle unless the result is stalled, and holds the result register.
`default_nettype none
module hfpd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire hfpd_pkg::cmd_t cmd,
  input  wire logic           cmd_empty,
  output logic                cmd_pop,
  output logic                res_valid,
  input  wire logic           res_stall,
  output hfpd_pkg::result_t   res
);
  import hfpd_pkg::*;

  logic [7:0] speed_r, speed_nxt;
  logic [7:0] angle_r, angle_nxt;
  logic [7:0] repeat_r, repeat_nxt;
  logic [7:0] pause_r, pause_nxt;
  logic [7:0] torque_r, torque_nxt;
  logic [2:0] state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [1:0] submode_r, submode_nxt;
  logic       start_nxt, reinit_nxt;
  logic       valid_r, valid_nxt;
  result_t    res_r, res_nxt;

  logic [11:0] prod11;
  logic [10:0] half;
  logic [7:0]  v;

  assign v         = cmd.value;
  assign cmd_pop   = !cmd_empty && (!valid_r || !res_stall);
  assign res_valid = valid_r;
  assign res       = res_r;

  // value*11/2 as shifts and adds, saturated to a byte
  assign prod11 = {4'b0, v} + {1'b0, v, 3'b0} + {3'b0, v, 1'b0};
  assign half   = prod11[11:1];

  // Command decode
  always_comb begin
    speed_nxt   = speed_r;
    angle_nxt   = angle_r;
    repeat_nxt  = repeat_r;
    pause_nxt   = pause_r;
    torque_nxt  = torque_r;
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    submode_nxt = submode_r;
    start_nxt   = 1'b0;
    reinit_nxt  = 1'b0;
    case (cmd.op)
      OP_SPEED:  speed_nxt  = v;
      OP_ANGLE:  angle_nxt  = (half[10:8] != 3'b0) ? 8'hFF : half[7:0];
      OP_REPEAT: repeat_nxt = v;
      OP_PAUSE:  pause_nxt  = v;
      OP_TORQUE: torque_nxt = {v[6:0], 1'b0} + TORQUE_BASE;
      OP_BUTTON, OP_BUTTON_MODE: begin
        case (v)
          BTN_START: begin
            state_nxt = RUN_RUNNING;
            start_nxt = 1'b1;
          end
          BTN_PAUSE: state_nxt = RUN_PAUSED;
          BTN_STOP:  state_nxt = RUN_STOPPED;
          BTN_IDLE:  state_nxt = RUN_IDLE;
          BTN_ESTOP: state_nxt = RUN_ESTOP;
          default: ;
        endcase
        // passive submode buttons only on the combined id
        if (cmd.op == OP_BUTTON_MODE && v >= BTN_SUB_LO && v <= BTN_SUB_HI) begin
          mode_nxt    = MODE_PASSIVE;
          submode_nxt = 2'(v - BTN_SUB_LO);
        end
      end
      OP_MODE: begin
        case (v)
          SEL_ACTIVE: begin
            mode_nxt   = MODE_ACTIVE;
            reinit_nxt = 1'b1;
          end
          SEL_PASSIVE: begin
            mode_nxt   = MODE_PASSIVE;
            reinit_nxt = 1'b1;
          end
          SEL_FORCE: mode_nxt = MODE_FORCE;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Output register control
  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (cmd_pop) begin
      valid_nxt               = 1'b1;
      res_nxt.speed_setting   = speed_nxt;
      res_nxt.angle_limit     = angle_nxt;
      res_nxt.repeat_setting  = repeat_nxt;
      res_nxt.pause_seconds   = pause_nxt;
      res_nxt.torque_setting  = torque_nxt;
      res_nxt.run_state       = state_nxt;
      res_nxt.operating_mode  = mode_nxt;
      res_nxt.passive_submode = submode_nxt;
      res_nxt.start_pulse     = start_nxt;
      res_nxt.reinit_pulse    = reinit_nxt;
    end else if (!res_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= SPEED_RST;
      angle_r   <= ANGLE_RST;
      repeat_r  <= REPEAT_RST;
      pause_r   <= PAUSE_RST;
      torque_r  <= TORQUE_RST;
      state_r   <= RUN_RUNNING;
      mode_r    <= MODE_ACTIVE;
      submode_r <= SUB_ASSIST;
      valid_r   <= 1'b0;
    end else begin
      if (cmd_pop) begin
        speed_r   <= speed_nxt;
        angle_r   <= angle_nxt;
        repeat_r  <= repeat_nxt;
        pause_r   <= pause_nxt;
        torque_r  <= torque_nxt;
        state_r   <= state_nxt;
        mode_r    <= mode_nxt;
        submode_r <= submode_nxt;
      end
      valid_r <= valid_nxt;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

>>> sv/hmi_frame_parameter_decoder.sv
// Top level of the display-panel serial frame parameter decoder.
//
//   channel  direction  handshake         payload
//   in       input      in_valid/in_stall   in_rx_byte
//   out      output     out_valid/out_stall out_speed_setting .. out_reinit_pulse
//
// One byte per clock is taken while the two-entry command queue has room.
// A completed frame leaves the front in the cycle of its last byte, is queued,
// then applied by the settings unit and shown from its result register.
// Reset (rst_n low, synchronous) returns to the header hunt and loads the
// default settings. in_stall rises only when the queue is full, which needs
// out_stall held across whole frames.
`default_nettype none
module hmi_frame_parameter_decoder #(
  parameter int unsigned FRAME_LENGTH = hfpd_pkg::FRAME_LENGTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_speed_setting,
  output logic [7:0]      out_angle_limit,
  output logic [7:0]      out_repeat_setting,
  output logic [7:0]      out_pause_seconds,
  output logic [7:0]      out_torque_setting,
  output logic [2:0]      out_run_state,
  output logic [1:0]      out_operating_mode,
  output logic [1:0]      out_passive_submode,
  output logic            out_start_pulse,
  output logic            out_reinit_pulse
);
  import hfpd_pkg::*;

  cmd_t    front_cmd, queue_cmd;
  logic    front_push, queue_full, queue_empty, queue_pop;
  result_t res;

  assign in_stall = queue_full;

  hfpd_front #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_take(in_valid && !queue_full),
    .rx_byte  (in_rx_byte),
    .cmd      (front_cmd),
    .cmd_push (front_push)
  );

  hfpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_push),
    .push_data(front_cmd),
    .full     (queue_full),
    .pop      (queue_pop),
    .pop_data (queue_cmd),
    .empty    (queue_empty)
  );

  hfpd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (queue_cmd),
    .cmd_empty(queue_empty),
    .cmd_pop  (queue_pop),
    .res_valid(out_valid),
    .res_stall(out_stall),
    .res      (res)
  );

  // Result fields
  assign out_speed_setting   = res.speed_setting;
  assign out_angle_limit     = res.angle_limit;
  assign out_repeat_setting  = res.repeat_setting;
  assign out_pause_seconds   = res.pause_seconds;
  assign out_torque_setting  = res.torque_setting;
  assign out_run_state       = res.run_state;
  assign out_operating_mode  = res.operating_mode;
  assign out_passive_submode = res.passive_submode;
  assign out_start_pulse     = res.start_pulse;
  assign out_reinit_pulse    = res.reinit_pulse;

endmodule
`default_nettype wire
